// ===== rtl/core/assert_macros.svh =====
// assertion macros included by the encoder top for its checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising edge, switched off while reset is low
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never be true
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    `ASSERT_CLKD(label, clk, rstn, !(cond), msg)

`endif

// ===== rtl/core/b32enc_pkg.sv =====
// types, constants and checksum helpers of the bech32 string encoder
package b32enc_pkg;

    typedef enum logic [1:0] {
        OP_PREFIX = 2'd0,
        OP_DATA   = 2'd1,
        OP_FINISH = 2'd2
    } opcode_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SEP  = 5'b00010,
        ST_DATA = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_FOUT = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'b001,
        PH_DATA   = 3'b010,
        PH_ERROR  = 3'b100
    } phase_t;

    localparam int          CHK_W       = 30;
    localparam logic [29:0] CHK_INIT    = 30'h1;
    localparam logic [29:0] CONST_BECH32  = 30'h0000_0001;
    localparam logic [29:0] CONST_BECH32M = 30'h2bc8_30a3;
    localparam logic [29:0] GEN_WORDS [5] = '{
        30'h3b6a_57b2, 30'h2650_8e6d, 30'h1ea1_19fa, 30'h3d42_33dd, 30'h2a14_62b3
    };

    localparam logic [7:0]   CHAR_MIN     = 8'd33;
    localparam logic [7:0]   CHAR_MAX     = 8'd126;
    localparam logic [7:0]   UPPER_FIRST  = 8'h41;
    localparam logic [7:0]   UPPER_LAST   = 8'h5a;
    localparam logic [7:0]   SEP_CHAR     = 8'h31;
    localparam logic [7:0]   ERR_CHAR     = 8'h00;
    localparam logic [255:0] SYMBOL_TABLE = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    // last of six steps, both for the zero folds and the checksum beats
    localparam logic [2:0] LAST_STEP = 3'd5;

    localparam logic REG_MODE = 1'b0;

    // one bch step: shift in five zero bits and reduce by the generator
    function automatic logic [29:0] b32_fold(input logic [29:0] c);
        logic [29:0] r;
        r = {c[24:0], 5'b00000};
        for (int k = 0; k < 5; k++) begin
            if (c[25 + k]) begin
                r = r ^ GEN_WORDS[k];
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] b32_symbol(input logic [4:0] idx);
        return SYMBOL_TABLE[8 * (5'd31 - idx) +: 8];
    endfunction

    function automatic logic bad_prefix_char(input logic [7:0] v);
        return (v < CHAR_MIN) || (v > CHAR_MAX) || ((v >= UPPER_FIRST) && (v <= UPPER_LAST));
    endfunction

endpackage

// ===== rtl/core/b32enc_prefix_ram.sv =====
// prefix character store: one write port, one registered read port
module b32enc_prefix_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bech32_string_encoder_top.sv =====
// bech32 / bech32m string encoder: control, checksum and output beat register
//
// Input stream s_*: s_tuser carries the opcode (prefix char, data value,
// finish), s_tdata the byte. Output stream m_*: one character per beat,
// m_tlast on the last character of a string (or on the error beat),
// m_tuser = {run_last, is_error}. Mode register (bech32m select) sits at
// address 0 of the apb port; the user must ensure it is written only while
// idle, which the block does not enforce. Prefix characters give no beat.
// A data value in the data phase gives its character in the next cycle, so
// data streams at one item per cycle while beats are taken. The first data
// value (or a finish with no data) replays the stored prefix from the
// prefix ram, one character per beat, then '1'. Finish runs six checksum
// folds, then six beats; an errored string finishes with one beat. The
// rate is set by the single output beat register and the one-fold-per-
// cycle checksum unit. s_tready is low while a multi-beat item is at work
// and whenever the output register holds a beat that is not being taken;
// a stalled receiver simply holds the block. Synchronous reset returns to
// an empty string, checksum one, bech32 mode; prefix ram contents stay.
module bech32_string_encoder_top #(
    parameter int PREFIX_MAX_LEN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic [1:0]  m_tuser,   // [0] is_error, [1] run_last
    output logic        m_tlast,   // string_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import b32enc_pkg::*;

    localparam int LW = $clog2(PREFIX_MAX_LEN + 1);
    localparam int AW = (PREFIX_MAX_LEN > 1) ? $clog2(PREFIX_MAX_LEN) : 1;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [29:0] chk_reg, chk_next;
    logic [LW-1:0] plen_reg, plen_next;
    logic [LW-1:0] sidx_reg, sidx_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [4:0]  val_reg, val_next;
    logic        pfin_reg, pfin_next;
    logic        mode_reg;

    logic        m_valid_reg;
    logic [7:0]  m_char_reg;
    logic        m_err_reg, m_last_reg, m_end_reg;

    logic        out_free, in_acc;
    logic        emit, e_err, e_last, e_end;
    logic [7:0]  e_char;
    logic        wr_en;
    logic [7:0]  rd_data;
    logic [29:0] chk_fold, fin_const;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign chk_fold = b32_fold(chk_reg);
    assign fin_const = mode_reg ? CONST_BECH32M : CONST_BECH32;

    b32enc_prefix_ram #(
        .DEPTH (PREFIX_MAX_LEN),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (plen_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (sidx_next[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        chk_next   = chk_reg;
        plen_next  = plen_reg;
        sidx_next  = sidx_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        pfin_next  = pfin_reg;
        wr_en      = 1'b0;
        emit       = 1'b0;
        e_char     = ERR_CHAR;
        e_err      = 1'b0;
        e_last     = 1'b0;
        e_end      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_tuser)
                        OP_PREFIX: begin
                            if ((phase_reg != PH_PREFIX) || bad_prefix_char(s_tdata) ||
                                (plen_reg >= LW'(PREFIX_MAX_LEN))) begin
                                phase_next = PH_ERROR;
                            end else begin
                                wr_en     = 1'b1;
                                plen_next = plen_reg + 1'b1;
                                chk_next  = chk_fold ^ {27'd0, s_tdata[7:5]};
                            end
                        end
                        OP_DATA: begin
                            if (phase_reg == PH_ERROR) begin
                                phase_next = PH_ERROR;
                            end else if (s_tdata[7:5] != 3'd0) begin
                                phase_next = PH_ERROR;
                            end else if (phase_reg == PH_PREFIX) begin
                                // separator: one zero fold, then the stored prefix
                                chk_next   = chk_fold;
                                val_next   = s_tdata[4:0];
                                pfin_next  = 1'b0;
                                sidx_next  = '0;
                                state_next = ST_SEP;
                            end else begin
                                chk_next = chk_fold ^ {25'd0, s_tdata[4:0]};
                                emit     = 1'b1;
                                e_char   = b32_symbol(s_tdata[4:0]);
                                e_last   = 1'b1;
                            end
                        end
                        OP_FINISH: begin
                            if (phase_reg == PH_ERROR) begin
                                emit       = 1'b1;
                                e_char     = ERR_CHAR;
                                e_err      = 1'b1;
                                e_last     = 1'b1;
                                e_end      = 1'b1;
                                chk_next   = CHK_INIT;
                                plen_next  = '0;
                                phase_next = PH_PREFIX;
                            end else if (phase_reg == PH_PREFIX) begin
                                chk_next   = chk_fold;
                                pfin_next  = 1'b1;
                                sidx_next  = '0;
                                state_next = ST_SEP;
                            end else begin
                                cnt_next   = '0;
                                state_next = ST_FIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEP: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (sidx_reg < plen_reg) begin
                        // rd_data holds the entry at sidx_reg
                        e_char    = rd_data;
                        chk_next  = chk_fold ^ {25'd0, rd_data[4:0]};
                        sidx_next = sidx_reg + 1'b1;
                    end else begin
                        e_char     = SEP_CHAR;
                        phase_next = PH_DATA;
                        cnt_next   = '0;
                        state_next = pfin_reg ? ST_FIN : ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_char     = b32_symbol(val_reg);
                    e_last     = 1'b1;
                    chk_next   = chk_fold ^ {25'd0, val_reg};
                    state_next = ST_IDLE;
                end
            end
            ST_FIN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    chk_next   = chk_fold ^ fin_const;
                    cnt_next   = '0;
                    state_next = ST_FOUT;
                end else begin
                    chk_next = chk_fold;
                end
            end
            ST_FOUT: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_char   = b32_symbol(chk_reg[29:25]);
                    chk_next = {chk_reg[24:0], 5'b00000};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP) begin
                        e_last     = 1'b1;
                        e_end      = 1'b1;
                        chk_next   = CHK_INIT;
                        plen_next  = '0;
                        phase_next = PH_PREFIX;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_PREFIX;
            chk_reg   <= CHK_INIT;
            plen_reg  <= '0;
            sidx_reg  <= '0;
            cnt_reg   <= '0;
            val_reg   <= '0;
            pfin_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            chk_reg   <= chk_next;
            plen_reg  <= plen_next;
            sidx_reg  <= sidx_next;
            cnt_reg   <= cnt_next;
            val_reg   <= val_next;
            pfin_reg  <= pfin_next;
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_char_reg <= e_char;
            m_err_reg  <= e_err;
            m_last_reg <= e_last;
            m_end_reg  <= e_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tuser  = {m_last_reg, m_err_reg};
    assign m_tlast  = m_end_reg;

    // apb mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE)) begin
            mode_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_reg} : 32'd0;

`include "assert_macros.svh"

    `ASSERT_NEVER(a_plen_max, aclk, aresetn, plen_reg > LW'(PREFIX_MAX_LEN), "prefix length beyond store depth")
    `ASSERT_CLKD(a_sep_idx, aclk, aresetn, (state_reg == ST_SEP) |-> (sidx_reg <= plen_reg), "replay index past prefix length")
    `ASSERT_CLKD(a_sep_phase, aclk, aresetn, (state_reg == ST_SEP) |-> (phase_reg == PH_PREFIX), "separator outside prefix phase")
    `ASSERT_CLKD(a_err_beat, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tuser[1] && (m_tdata == ERR_CHAR)), "error beat not closing the string")

endmodule
